[src/pus_pkg.sv]
// png scanline unfilter: shared payload types, filter codes and register indexes
// no dependencies
`default_nettype none

package pus_pkg;

  localparam logic [2:0] FILT_NONE  = 3'd0;
  localparam logic [2:0] FILT_SUB   = 3'd1;
  localparam logic [2:0] FILT_UP    = 3'd2;
  localparam logic [2:0] FILT_AVG   = 3'd3;
  localparam logic [2:0] FILT_PAETH = 3'd4;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_LINE_WIDTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LINE_COUNT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HAS_ALPHA  = 2'd2;

  typedef struct packed {
    logic [2:0] filter_kind;
    logic [7:0] in_red;
    logic [7:0] in_green;
    logic [7:0] in_blue;
    logic [7:0] in_alpha;
  } pix_t;

  typedef struct packed {
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic [7:0] out_alpha;
    logic       row_end;
    logic       image_end;
  } res_t;

endpackage

`default_nettype wire

[src/pus_ifs.sv]
// png scanline unfilter: valid/ready channel interfaces for pixels, results and config
// depends on pus_pkg
`default_nettype none

interface pus_pix_if
  import pus_pkg::*;
  ();
  logic valid;
  logic ready;
  pix_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface pus_res_if
  import pus_pkg::*;
  ();
  logic valid;
  logic ready;
  res_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface pus_cfg_if
  import pus_pkg::*;
  ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

[src/png_scanline_unfilter.sv]
// png scanline unfilter top level: position counters, line store, filter reconstruction
// an accepted item is registered into the reconstruction stage, then into the result register
//   when that stage advances; one item per cycle sustained while result.ready holds, set by the
//   line store read issued at accept and the reconstruction in the next stage
// the line store read is forwarded from the write of the same cycle on one-pixel lines
// reset (rst, synchronous): counters, latched filter, neighbors and config return to
//   width 1, count 1, rgb; the line store is not cleared
`default_nettype none

module png_scanline_unfilter
  import pus_pkg::*;
#(
  parameter int unsigned MAX_WIDTH = 1024
) (
  input  wire      clk,
  input  wire      rst,
  pus_cfg_if.sink  cfg,
  pus_pix_if.sink  pixel,
  pus_res_if.source result
);

  localparam int unsigned CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int unsigned XW = (CW + 1 > 11) ? CW + 1 : 11;
  localparam logic [XW-1:0] MAX_X = XW'(MAX_WIDTH);

  typedef struct packed {
    logic [CW-1:0] col;
    logic          col0;
    logic          first_row;
    logic [2:0]    filt;
    logic          last_col;
    logic          last_row;
    logic [31:0]   raw;
  } s1_t;

  function automatic logic [7:0] paeth8(input logic [7:0] a, input logic [7:0] b,
                                        input logic [7:0] c);
    logic [9:0] pa;
    logic [9:0] pb;
    logic [9:0] pc;
    logic [9:0] s;
    logic [9:0] cc;
    logic [7:0] r;
    pa = (b > c) ? {2'b0, b - c} : {2'b0, c - b};
    pb = (a > c) ? {2'b0, a - c} : {2'b0, c - a};
    s  = {2'b0, a} + {2'b0, b};
    cc = {1'b0, c, 1'b0};
    pc = (s > cc) ? s - cc : cc - s;
    if (pa <= pb && pa <= pc) begin
      r = a;
    end else if (pb <= pc) begin
      r = b;
    end else begin
      r = c;
    end
    return r;
  endfunction

  function automatic logic [7:0] pred8(input logic [2:0] f, input logic [7:0] a,
                                       input logic [7:0] b, input logic [7:0] c);
    logic [8:0] sum;
    logic [7:0] p;
    sum = {1'b0, a} + {1'b0, b};
    case (f)
      FILT_SUB:   p = a;
      FILT_UP:    p = b;
      FILT_AVG:   p = sum[8:1];
      FILT_PAETH: p = paeth8(a, b, c);
      default:    p = 8'd0;
    endcase
    return p;
  endfunction

  logic [10:0]   line_width;
  logic [15:0]   line_count;
  logic          has_alpha;

  logic [CW-1:0] col;
  logic [15:0]   row;
  logic [2:0]    row_filter;
  logic [31:0]   left_pixel;
  logic [31:0]   upleft_pixel;

  logic          s1_valid;
  s1_t           s1;
  logic          out_valid;
  res_t          out_data;

  logic [31:0]   prior_row [MAX_WIDTH];
  logic [31:0]   mem_q;
  logic          fwd;
  logic [31:0]   fwd_data;

  logic          accept;
  logic          s1_adv;
  logic [XW-1:0] w_one;
  logic [XW-1:0] w_eff;
  logic [XW-1:0] col_inc;
  logic [16:0]   cnt_eff;
  logic [16:0]   row_inc;
  logic          last_col;
  logic          last_row;
  logic          col0;
  logic [2:0]    filt;
  logic [31:0]   raw_in;
  logic [31:0]   a_px;
  logic [31:0]   b_px;
  logic [31:0]   c_px;
  logic [31:0]   res_full;
  logic [31:0]   res;

  // config port
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      line_width <= 11'd1;
      line_count <= 16'd1;
      has_alpha  <= 1'b0;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_LINE_WIDTH: line_width <= cfg.data[10:0];
        REG_LINE_COUNT: line_count <= cfg.data;
        REG_HAS_ALPHA:  has_alpha  <= cfg.data[0];
        default: ;
      endcase
    end
  end

  // handshake
  assign s1_adv      = s1_valid && (!out_valid || result.ready);
  assign pixel.ready = !s1_valid || s1_adv;
  assign accept      = pixel.valid && pixel.ready;

  // position, filter kind and raw value of the incoming item
  always_comb begin
    w_one    = (line_width == 11'd0) ? XW'(1) : XW'(line_width);
    w_eff    = (w_one > MAX_X) ? MAX_X : w_one;
    col_inc  = XW'(col) + XW'(1);
    last_col = col_inc >= w_eff;
    cnt_eff  = (line_count == 16'd0) ? 17'd1 : {1'b0, line_count};
    row_inc  = {1'b0, row} + 17'd1;
    last_row = row_inc >= cnt_eff;
    col0     = col == '0;
    filt     = col0 ? pixel.data.filter_kind : row_filter;
    raw_in   = {has_alpha ? pixel.data.in_alpha : 8'd0, pixel.data.in_blue,
                pixel.data.in_green, pixel.data.in_red};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col        <= '0;
      row        <= '0;
      row_filter <= FILT_NONE;
      s1_valid   <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid <= 1'b1;
        if (col0) begin
          row_filter <= pixel.data.filter_kind;
        end
        if (last_col) begin
          col <= '0;
          row <= last_row ? 16'd0 : row_inc[15:0];
        end else begin
          col <= col_inc[CW-1:0];
        end
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1.col       <= col;
      s1.col0      <= col0;
      s1.first_row <= row == 16'd0;
      s1.filt      <= filt;
      s1.last_col  <= last_col;
      s1.last_row  <= last_row;
      s1.raw       <= raw_in;
    end
  end

  // line store, read at accept, written when the item leaves the reconstruction stage
  always_ff @(posedge clk) begin
    if (s1_adv) begin
      prior_row[s1.col] <= res;
    end
    if (accept) begin
      mem_q    <= prior_row[col];
      fwd      <= s1_adv && (s1.col == col);
      fwd_data <= res;
    end
  end

  // reconstruction
  always_comb begin
    a_px = s1.col0 ? 32'd0 : left_pixel;
    b_px = s1.first_row ? 32'd0 : (fwd ? fwd_data : mem_q);
    c_px = (s1.col0 || s1.first_row) ? 32'd0 : upleft_pixel;
  end

  for (genvar k = 0; k < 4; k++) begin : g_chan
    assign res_full[8*k +: 8] = s1.raw[8*k +: 8] +
                                pred8(s1.filt, a_px[8*k +: 8], b_px[8*k +: 8], c_px[8*k +: 8]);
  end

  assign res = has_alpha ? res_full : {8'd0, res_full[23:0]};

  always_ff @(posedge clk) begin
    if (rst) begin
      left_pixel   <= '0;
      upleft_pixel <= '0;
      out_valid    <= 1'b0;
    end else if (s1_adv) begin
      left_pixel   <= res;
      upleft_pixel <= b_px;
      out_valid    <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_data.out_red   <= res[7:0];
      out_data.out_green <= res[15:8];
      out_data.out_blue  <= res[23:16];
      out_data.out_alpha <= res[31:24];
      out_data.row_end   <= s1.last_col;
      out_data.image_end <= s1.last_col && s1.last_row;
    end
  end

  assign result.valid = out_valid;
  assign result.data  = out_data;

  a_col_wrap: assert property (@(posedge clk) disable iff (rst)
    accept && last_col |=> col == '0)
    else $error("column did not wrap after the last pixel of a line");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_adv |=> s1_valid && $stable(s1))
    else $error("reconstruction stage lost its item while stalled");

  a_image_end_row: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.image_end |-> out_data.row_end)
    else $error("image end without row end");

  a_fwd_line: assert property (@(posedge clk) disable iff (rst)
    s1_valid && fwd |-> s1.col0)
    else $error("line store forward taken away from column zero");

  a_rgb_alpha: assert property (@(posedge clk) disable iff (rst)
    s1_adv && !has_alpha |=> out_data.out_alpha == 8'd0)
    else $error("nonzero alpha in rgb mode");

endmodule

`default_nettype wire

[tb/sv/unfilter_checker.sv]
// png scanline unfilter checker: watches the config, pixel and result channels, rebuilds
// each pixel on its own copy of the state and compares every result item field by field
// depends on pus_pkg and the channel interfaces in pus_ifs
`default_nettype none

module unfilter_checker
  import pus_pkg::*;
#(
  parameter int unsigned LINE_MAX = 1024
) (
  input  wire         clk,
  input  wire         rst,
  pus_cfg_if          cfg,
  pus_pix_if          pixel,
  pus_res_if          result,
  output int unsigned awaiting,
  output int unsigned fail_count
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [10:0] width_reg;
  logic [15:0] count_reg;
  logic        alpha_on;
  logic [31:0] prev_line [LINE_MAX];
  logic [31:0] west_px;
  logic [31:0] northwest_px;
  int unsigned col_at;
  int unsigned row_at;
  logic [2:0]  kind_latched;
  res_t        rebuilt_q [$];

  function automatic int paeth_pick(int a, int b, int c);
    int da;
    int db;
    int dc;
    da = (b > c) ? b - c : c - b;
    db = (a > c) ? a - c : c - a;
    dc = (a + b > 2 * c) ? a + b - 2 * c : 2 * c - a - b;
    if (da <= db && da <= dc) return a;
    if (db <= dc) return b;
    return c;
  endfunction

  function automatic res_t rebuild(pix_t px);
    int unsigned w_eff;
    int unsigned c_eff;
    int unsigned col;
    int unsigned k;
    int          a;
    int          b;
    int          c;
    int          pred;
    logic [31:0] a_px;
    logic [31:0] b_px;
    logic [31:0] c_px;
    logic [31:0] raw;
    logic [31:0] got;
    logic        top_line;
    logic        line_done;
    logic        last_line;
    res_t        r;
    w_eff = (width_reg == 0) ? 1 : ((width_reg > LINE_MAX) ? LINE_MAX : width_reg);
    c_eff = (count_reg == 0) ? 1 : count_reg;
    col = (col_at >= LINE_MAX) ? LINE_MAX - 1 : col_at;
    top_line = (row_at == 0);
    if (col == 0) kind_latched = px.filter_kind;
    a_px = (col == 0) ? 32'h0 : west_px;
    b_px = top_line ? 32'h0 : prev_line[col];
    c_px = (col == 0 || top_line) ? 32'h0 : northwest_px;
    raw = {alpha_on ? px.in_alpha : 8'h00, px.in_blue, px.in_green, px.in_red};
    for (k = 0; k < 4; k++) begin
      a = a_px[8*k +: 8];
      b = b_px[8*k +: 8];
      c = c_px[8*k +: 8];
      case (kind_latched)
        FILT_SUB:   pred = a;
        FILT_UP:    pred = b;
        FILT_AVG:   pred = (a + b) / 2;
        FILT_PAETH: pred = paeth_pick(a, b, c);
        default:    pred = 0;
      endcase
      got[8*k +: 8] = raw[8*k +: 8] + 8'(pred);
    end
    if (!alpha_on) got[31:24] = 8'h00;
    northwest_px = b_px;
    west_px = got;
    prev_line[col] = got;
    line_done = (col_at + 1 >= w_eff);
    last_line = (row_at + 1 >= c_eff);
    if (line_done) begin
      col_at = 0;
      row_at = last_line ? 0 : ((row_at + 1) & 32'hffff);
    end else begin
      col_at++;
    end
    r.out_red   = got[7:0];
    r.out_green = got[15:8];
    r.out_blue  = got[23:16];
    r.out_alpha = got[31:24];
    r.row_end   = line_done;
    r.image_end = line_done && last_line;
    return r;
  endfunction

  task automatic check_field(string field, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0h, got %0h", $time, field, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    res_t want;
    if (rst) begin
      width_reg = 11'd1;
      count_reg = 16'd1;
      alpha_on = 1'b0;
      west_px = '0;
      northwest_px = '0;
      col_at = 0;
      row_at = 0;
      kind_latched = FILT_NONE;
      rebuilt_q.delete();
    end else begin
      if (result.valid && result.ready) begin
        if (rebuilt_q.size() == 0) begin
          $display("%0t: result item with no pixel outstanding: %h", $time, result.data);
          fail_count++;
        end else begin
          want = rebuilt_q.pop_front();
          check_field("out_red", want.out_red, result.data.out_red);
          check_field("out_green", want.out_green, result.data.out_green);
          check_field("out_blue", want.out_blue, result.data.out_blue);
          check_field("out_alpha", want.out_alpha, result.data.out_alpha);
          check_field("row_end", want.row_end, result.data.row_end);
          check_field("image_end", want.image_end, result.data.image_end);
        end
      end
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          REG_LINE_WIDTH: width_reg = cfg.data[10:0];
          REG_LINE_COUNT: count_reg = cfg.data;
          REG_HAS_ALPHA:  alpha_on = cfg.data[0];
          default: ;
        endcase
      end
      if (pixel.valid && pixel.ready) rebuilt_q = {rebuilt_q, rebuild(pixel.data)};
    end
    awaiting <= rebuilt_q.size();
  end

endmodule

`default_nettype wire

[tb/sv/testbench.sv]
// png scanline unfilter testbench top: clock, reset, config writes, pixel stimulus and
// result back-pressure; directed images first, then random images with mid-image changes
// depends on pus_pkg, pus_ifs, unfilter_checker and png_scanline_unfilter
`default_nettype none

module testbench
  import pus_pkg::*;
  ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned LINE_MAX = 1024;
  localparam int unsigned RANDOM_ITEMS = 300;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned IMAGE_REST = 32'hffff_ffff;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
  localparam logic [2:0] FILT_RSVD5 = 3'd5;
  localparam logic [2:0] FILT_RSVD6 = 3'd6;
  localparam logic [2:0] FILT_RSVD7 = 3'd7;

  logic        clk = 1'b0;
  logic        rst;
  logic        steady;
  int unsigned awaiting;
  int unsigned fail_count;
  int unsigned run_width;
  int unsigned run_lines;
  int unsigned next_col;
  int unsigned next_row;
  int unsigned pixels_sent;
  logic [2:0]  row_kind;

  pus_cfg_if cfg_ch ();
  pus_pix_if pix_ch ();
  pus_res_if res_ch ();

  png_scanline_unfilter #(
    .MAX_WIDTH(LINE_MAX)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .cfg(cfg_ch),
    .pixel(pix_ch),
    .result(res_ch)
  );

  unfilter_checker #(
    .LINE_MAX(LINE_MAX)
  ) i_checker (
    .clk(clk),
    .rst(rst),
    .cfg(cfg_ch),
    .pixel(pix_ch),
    .result(res_ch),
    .awaiting(awaiting),
    .fail_count(fail_count)
  );

  always #4 clk = ~clk;

  function automatic int unsigned pause_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 75) return $urandom_range(1, 2);
    if (r < 95) return $urandom_range(3, 6);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [7:0] pick_byte();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return 8'h00;
    if (r == 1) return 8'hff;
    return 8'($urandom);
  endfunction

  function automatic logic [2:0] pick_row_kind();
    case ($urandom_range(0, 11))
      0, 1:    return FILT_NONE;
      2, 3:    return FILT_SUB;
      4, 5:    return FILT_UP;
      6, 7:    return FILT_AVG;
      8, 9:    return FILT_PAETH;
      10:      return FILT_RSVD5;
      default: return $urandom_range(0, 1) ? FILT_RSVD6 : FILT_RSVD7;
    endcase
  endfunction

  function automatic logic [15:0] pick_width();
    logic [10:0] w;
    case ($urandom_range(0, 19))
      0:       w = 11'd0;
      1, 2:    w = 11'($urandom_range(13, 64));
      default: w = 11'($urandom_range(1, 12));
    endcase
    return {5'($urandom), w};
  endfunction

  function automatic logic [15:0] pick_count();
    if ($urandom_range(0, 9) == 0) return 16'd0;
    return 16'($urandom_range(1, 5));
  endfunction

  function automatic pix_t px_of(logic [2:0] kind, logic [7:0] r, logic [7:0] g,
                                 logic [7:0] b, logic [7:0] a);
    pix_t px;
    px.filter_kind = kind;
    px.in_red = r;
    px.in_green = g;
    px.in_blue = b;
    px.in_alpha = a;
    return px;
  endfunction

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_LINE_WIDTH:
        run_width = (value[10:0] == 0) ? 1 :
                    ((value[10:0] > LINE_MAX) ? LINE_MAX : value[10:0]);
      REG_LINE_COUNT: run_lines = (value == 0) ? 1 : value;
      default: ;
    endcase
  endtask

  task automatic send_pixel(pix_t px);
    int unsigned gap;
    gap = (!steady && $urandom_range(0, 2) == 0) ? pause_len() : 0;
    if (gap > 0) begin
      pix_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pix_ch.valid <= 1'b1;
    pix_ch.data <= px;
    do @(posedge clk); while (!pix_ch.ready);
    pixels_sent++;
    if (next_col + 1 >= run_width) begin
      next_col = 0;
      next_row = (next_row + 1 >= run_lines) ? 0 : next_row + 1;
    end else begin
      next_col++;
    end
  endtask

  // stops at the image boundary or after limit items
  task automatic send_run(int unsigned limit);
    int unsigned n;
    pix_t        px;
    n = 0;
    do begin
      if (next_col == 0) row_kind = pick_row_kind();
      px.filter_kind = (next_col == 0 || $urandom_range(0, 3) != 0) ?
                       row_kind : 3'($urandom_range(0, 7));
      px.in_red = pick_byte();
      px.in_green = pick_byte();
      px.in_blue = pick_byte();
      px.in_alpha = pick_byte();
      send_pixel(px);
      n++;
    end while (n < limit && (next_col != 0 || next_row != 0));
  endtask

  task automatic settle();
    pix_ch.valid <= 1'b0;
    do @(posedge clk); while (awaiting != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    int unsigned hold;
    hold = 0;
    res_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst) begin
        res_ch.ready <= 1'b0;
      end else if (hold > 0) begin
        res_ch.ready <= 1'b0;
        hold--;
      end else begin
        res_ch.ready <= 1'b1;
        if (!steady && $urandom_range(0, 3) == 0) hold = pause_len();
      end
    end
  end

  initial begin
    int unsigned random_base;
    rst <= 1'b1;
    steady <= 1'b0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.index <= REG_LINE_WIDTH;
    cfg_ch.data <= '0;
    pix_ch.valid <= 1'b0;
    pix_ch.data <= '0;
    run_width = 1;
    run_lines = 1;
    next_col = 0;
    next_row = 0;
    pixels_sent = 0;
    row_kind = FILT_NONE;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // 3x3 rgba, wraparound and filter kind ignored off column 0
    write_reg(REG_LINE_WIDTH, 16'hf803);
    write_reg(REG_LINE_COUNT, 16'd3);
    write_reg(REG_HAS_ALPHA, 16'hffff);
    write_reg(REG_SPARE, 16'h5a5a);
    send_pixel(px_of(FILT_SUB, 8'hff, 8'hff, 8'hff, 8'hff));
    send_pixel(px_of(FILT_NONE, 8'hff, 8'h00, 8'hff, 8'h00));
    send_pixel(px_of(FILT_PAETH, 8'h01, 8'h02, 8'h03, 8'h04));
    send_pixel(px_of(FILT_AVG, 8'hff, 8'hff, 8'h00, 8'h00));
    send_pixel(px_of(FILT_UP, 8'h00, 8'hff, 8'h80, 8'h07));
    send_pixel(px_of(FILT_AVG, 8'h09, 8'h09, 8'h09, 8'h09));
    send_pixel(px_of(FILT_PAETH, 8'h00, 8'h00, 8'h00, 8'h00));
    send_pixel(px_of(FILT_PAETH, 8'hff, 8'h01, 8'h80, 8'hc8));
    send_pixel(px_of(FILT_NONE, pick_byte(), pick_byte(), pick_byte(), pick_byte()));
    settle();

    // zero width acts as one column, rgb, reserved kinds
    write_reg(REG_LINE_WIDTH, 16'h0000);
    write_reg(REG_LINE_COUNT, 16'd4);
    write_reg(REG_HAS_ALPHA, 16'hfffe);
    send_pixel(px_of(FILT_NONE, 8'h0a, 8'h14, 8'h1e, 8'hff));
    send_pixel(px_of(FILT_UP, 8'hff, 8'hff, 8'hff, 8'hff));
    send_pixel(px_of(FILT_RSVD5, 8'h01, 8'h01, 8'h01, 8'h01));
    send_pixel(px_of(FILT_RSVD7, 8'h00, 8'h00, 8'h00, 8'h00));
    settle();

    // zero count acts as one line
    write_reg(REG_LINE_WIDTH, 16'h0802);
    write_reg(REG_LINE_COUNT, 16'h0000);
    write_reg(REG_HAS_ALPHA, 16'h0001);
    send_pixel(px_of(FILT_RSVD6, 8'hc8, 8'h64, 8'h32, 8'h19));
    send_pixel(px_of(FILT_SUB, 8'hff, 8'hff, 8'hff, 8'hff));
    settle();

    // full-width line, then shrink the line and image mid-way
    write_reg(REG_LINE_WIDTH, 16'hffff);
    write_reg(REG_LINE_COUNT, 16'hffff);
    write_reg(REG_HAS_ALPHA, 16'h0001);
    send_run(LINE_MAX / 2);
    settle();
    write_reg(REG_LINE_WIDTH, 16'(LINE_MAX));
    send_run(LINE_MAX / 2 + 24);
    settle();
    write_reg(REG_LINE_WIDTH, 16'd20);
    write_reg(REG_LINE_COUNT, 16'd2);
    send_run(IMAGE_REST);
    settle();

    random_base = pixels_sent;
    while (pixels_sent - random_base < RANDOM_ITEMS) begin
      steady <= ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 3) != 0) write_reg(REG_LINE_WIDTH, pick_width());
      if ($urandom_range(0, 3) != 0) write_reg(REG_LINE_COUNT, pick_count());
      if ($urandom_range(0, 1) != 0) write_reg(REG_HAS_ALPHA, 16'($urandom));
      if ($urandom_range(0, 15) == 0) write_reg(REG_SPARE, 16'($urandom));
      repeat ($urandom_range(1, 3)) begin
        if ($urandom_range(0, 4) == 0 && run_width * run_lines > 1) begin
          send_run($urandom_range(1, run_width * run_lines - 1));
          settle();
          case ($urandom_range(0, 2))
            0:       write_reg(REG_LINE_WIDTH, 16'($urandom_range(0, run_width)));
            1:       write_reg(REG_LINE_COUNT, 16'($urandom_range(0, 6)));
            default: write_reg(REG_HAS_ALPHA, 16'($urandom_range(0, 1)));
          endcase
        end
        send_run(IMAGE_REST);
      end
      settle();
    end

    if (fail_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #8_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

`default_nettype wire

[filelist.f]
src/pus_pkg.sv
src/pus_ifs.sv
src/png_scanline_unfilter.sv
tb/sv/unfilter_checker.sv
tb/sv/testbench.sv
